// File: hw/rtl/lrupr_pkg.sv
package lrupr_pkg;

  localparam int NUM_FRAMES_DEF = 4;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 4;
  localparam int COUNT_W = 32;

  typedef struct packed {
    logic               is_fault;
    logic [FRAME_W-1:0] frame_used;
    logic               victim_valid;
    logic [PAGE_W-1:0]  evicted_page;
  } lookup_t;

endpackage

// File: hw/rtl/lrupr_frames.sv
module lrupr_frames #(
  parameter int NUM_FRAMES = lrupr_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ref_valid,
  input  logic [((PAGE_BITS < lrupr_pkg::PAGE_W) ? PAGE_BITS : lrupr_pkg::PAGE_W)-1:0] ref_page,
  output lrupr_pkg::lookup_t       res
);
  import lrupr_pkg::*;

  localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int FW = $clog2(NUM_FRAMES);
  localparam int RW = $clog2(NUM_FRAMES);

  logic [PW-1:0]   page_r  [NUM_FRAMES];
  logic [RW-1:0]   rank_r  [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_r;

  logic          hit;
  logic [FW-1:0] hit_idx;
  logic [RW-1:0] hit_rank;
  logic          empty;
  logic [FW-1:0] empty_idx;
  logic [FW-1:0] vic_idx;
  logic [FW-1:0] sel;

  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    hit_rank  = '0;
    empty     = 1'b0;
    empty_idx = '0;
    vic_idx   = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (valid_r[i] && page_r[i] == ref_page) begin
        hit      = 1'b1;
        hit_idx  = FW'(i);
        hit_rank = rank_r[i];
      end
      if (!valid_r[i]) begin
        empty     = 1'b1;
        empty_idx = FW'(i);
      end
      if (rank_r[i] == RW'(NUM_FRAMES - 1)) begin
        vic_idx = FW'(i);
      end
    end
    sel = hit ? hit_idx : (empty ? empty_idx : vic_idx);
  end

  always_comb begin
    res.is_fault     = !hit;
    res.frame_used   = FRAME_W'(sel);
    res.victim_valid = !hit && !empty;
    res.evicted_page = (!hit && !empty) ? PAGE_W'(page_r[vic_idx]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        rank_r[i] <= '0;
        page_r[i] <= '0;
      end
    end else if (ref_valid) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (FW'(i) == sel) begin
          rank_r[i] <= '0;
          if (!hit) begin
            page_r[i]  <= ref_page;
            valid_r[i] <= 1'b1;
          end
        end else if (valid_r[i] && (!hit || rank_r[i] < hit_rank)) begin
          rank_r[i] <= rank_r[i] + RW'(1);
        end
      end
    end
  end

endmodule

// File: hw/rtl/lru_page_replacement.sv
// LRU page replacement over NUM_FRAMES frames.
// Input: pulse start with in_page_number for one cycle; the item is taken at
// the clock edge where start is high and busy is low. busy stays low, so a
// reference may be presented in every cycle.
// Output: for each accepted reference, out_valid is high for exactly
// one cycle with out_is_fault, out_frame_used, out_victim_valid,
// out_evicted_page and out_fault_total. One result per reference, in order.
// Throughput is one reference per cycle; each reference passes the input
// register and then the result register. The frame match, empty
// search, victim pick and rank update are one pass of parallel compares.
// The receiver cannot stall; results are presented once and not held.
// Reset (rst_n low, synchronous) empties every frame, clears all ranks and
// the fault count, and drops any reference in flight.
// The fault count saturates at its maximum.
module lru_page_replacement #(
  parameter int NUM_FRAMES = lrupr_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lrupr_pkg::PAGE_W-1:0]  in_page_number,
  output logic                          out_valid,
  output logic                          out_is_fault,
  output logic [lrupr_pkg::FRAME_W-1:0] out_frame_used,
  output logic                          out_victim_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]  out_evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0] out_fault_total
);
  import lrupr_pkg::*;

  localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

  logic                ref_valid_r;
  logic [PW-1:0]       ref_page_r;
  lookup_t             res;
  logic                res_valid_r;
  lookup_t             res_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic [COUNT_W-1:0]  cnt_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_valid_r <= 1'b0;
    end else begin
      ref_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ref_page_r <= in_page_number[PW-1:0];
    end
  end

  lrupr_frames #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_frames (
    .clk       (clk),
    .rst_n     (rst_n),
    .ref_valid (ref_valid_r),
    .ref_page  (ref_page_r),
    .res       (res)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (ref_valid_r && res.is_fault && cnt_r != '1) begin
      cnt_nxt = cnt_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      res_valid_r <= ref_valid_r;
      cnt_r       <= cnt_nxt;
    end
  end

  // hold the result for its single output cycle
  always_ff @(posedge clk) begin
    if (ref_valid_r) begin
      res_r <= res;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_is_fault     = res_r.is_fault;
  assign out_frame_used   = res_r.frame_used;
  assign out_victim_valid = res_r.victim_valid;
  assign out_evicted_page = res_r.evicted_page;
  assign out_fault_total  = cnt_r;

endmodule

// File: dv/tb_top.sv
module tb_top;

  import lrupr_pkg::*;

  localparam int NUM_FRAMES  = NUM_FRAMES_DEF;
  localparam int RANK_W      = $clog2(NUM_FRAMES);
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_REFS = 950;
  localparam logic [PAGE_W-1:0] PAGE_MASK = PAGE_W'((64'd1 << PAGE_BITS_DEF) - 64'd1);

  typedef struct packed {
    lookup_t            lookup;
    logic [COUNT_W-1:0] fault_total;
  } page_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [PAGE_W-1:0]  in_page_number = '0;
  logic               out_valid;
  logic               out_is_fault;
  logic [FRAME_W-1:0] out_frame_used;
  logic               out_victim_valid;
  logic [PAGE_W-1:0]  out_evicted_page;
  logic [COUNT_W-1:0] out_fault_total;

  logic [PAGE_W-1:0]  frame_page_q  [NUM_FRAMES];
  logic               frame_valid_q [NUM_FRAMES];
  logic [RANK_W-1:0]  rank_q        [NUM_FRAMES];
  logic [COUNT_W-1:0] fault_count_q = '0;

  logic [PAGE_W-1:0]  page_refs[$];
  page_result_t       expected_results[$];
  logic               took_item = 1'b0;
  int                 items_sent = 0;
  int                 idle_cycles = 0;
  int                 mismatch_count = 0;

  lru_page_replacement DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_is_fault     (out_is_fault),
    .out_frame_used   (out_frame_used),
    .out_victim_valid (out_victim_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_total  (out_fault_total)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void lru_lookup(input logic [PAGE_W-1:0] page_in,
                                     output page_result_t res);
    logic [PAGE_W-1:0] page;
    logic [RANK_W-1:0] hit_rank;
    int                hit_idx;
    int                empty_idx;
    int                slot;
    page      = page_in & PAGE_MASK;
    hit_idx   = -1;
    empty_idx = -1;
    res       = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (frame_valid_q[i] && frame_page_q[i] == page && hit_idx < 0) hit_idx = i;
      if (!frame_valid_q[i] && empty_idx < 0) empty_idx = i;
    end
    if (hit_idx >= 0) begin
      slot     = hit_idx;
      hit_rank = rank_q[hit_idx];
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (i != hit_idx && frame_valid_q[i] && rank_q[i] < hit_rank) rank_q[i]++;
      end
      rank_q[hit_idx] = '0;
    end else begin
      res.lookup.is_fault = 1'b1;
      if (fault_count_q != '1) fault_count_q++;
      if (empty_idx >= 0) begin
        slot = empty_idx;
      end else begin
        slot = 0;
        for (int i = 1; i < NUM_FRAMES; i++) begin
          if (rank_q[i] > rank_q[slot]) slot = i;
        end
        res.lookup.victim_valid = 1'b1;
        res.lookup.evicted_page = frame_page_q[slot];
      end
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (i != slot && frame_valid_q[i]) rank_q[i]++;
      end
      frame_page_q[slot]  = page;
      frame_valid_q[slot] = 1'b1;
      rank_q[slot]        = '0;
    end
    res.lookup.frame_used = FRAME_W'(slot);
    res.fault_total       = fault_count_q;
  endfunction

  function automatic int sender_idle_pct(input int sent);
    if (sent < 320) return 31;
    if (sent < 640) return 71;
    return 0;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (page_refs.size() != 0 && $urandom_range(99) >= sender_idle_pct(items_sent)) begin
        start          <= 1'b1;
        in_page_number <= page_refs.pop_front();
        items_sent     <= items_sent + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    page_result_t res;
    page_result_t exp_res;
    if (!rst_n) begin
      took_item <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        frame_page_q[i]  = '0;
        frame_valid_q[i] = 1'b0;
        rank_q[i]        = '0;
      end
      fault_count_q = '0;
    end else begin
      took_item <= start && !busy;
      if (start && !busy) begin
        lru_lookup(in_page_number, res);
        expected_results.insert(expected_results.size(), res);
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: frame %0d fault %0d", out_frame_used, out_is_fault);
          mismatch_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_is_fault !== exp_res.lookup.is_fault) begin
            $error("is_fault: expected %0d, got %0d", exp_res.lookup.is_fault, out_is_fault);
            mismatch_count++;
          end
          if (out_frame_used !== exp_res.lookup.frame_used) begin
            $error("frame_used: expected %0d, got %0d",
                   exp_res.lookup.frame_used, out_frame_used);
            mismatch_count++;
          end
          if (out_victim_valid !== exp_res.lookup.victim_valid) begin
            $error("victim_valid: expected %0d, got %0d",
                   exp_res.lookup.victim_valid, out_victim_valid);
            mismatch_count++;
          end
          if (out_evicted_page !== exp_res.lookup.evicted_page) begin
            $error("evicted_page: expected %h, got %h",
                   exp_res.lookup.evicted_page, out_evicted_page);
            mismatch_count++;
          end
          if (out_fault_total !== exp_res.fault_total) begin
            $error("fault_total: expected %0d, got %0d", exp_res.fault_total, out_fault_total);
            mismatch_count++;
          end
        end
      end
    end
    if ((start && !busy && rst_n) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [PAGE_W-1:0] pool [8];
    int                pool_size;
    page_refs = '{16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hFFFF,
                  16'h0000, 16'h0002, 16'h8000, 16'h0001, 16'hAAAA, 16'h5555,
                  16'h5555, 16'h0001, 16'h7FFF, 16'h0000, 16'hAAAA, 16'hFFFE};
    pool_size = 0;
    for (int k = 0; k < RANDOM_REFS; k++) begin
      if (k % 40 == 0) begin
        pool_size = $urandom_range(3, 7);
        for (int p = 0; p < 8; p++) pool[p] = PAGE_W'($urandom_range(0, 65535));
      end
      if ($urandom_range(99) < 80) begin
        page_refs.insert(page_refs.size(), pool[3'($urandom_range(0, pool_size - 1))]);
      end else begin
        page_refs.insert(page_refs.size(), PAGE_W'($urandom_range(0, 65535)));
      end
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (page_refs.size() != 0 || start || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
